FILE: sv/alru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alru_pkg
// Operation codes and controller state type for the age counter LRU block.
// ----------------------------------------------------------------------------
package alru_pkg;

    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_FIND_FREE    = 3'd1;
    localparam logic [2:0] OP_EVICT_OLDEST = 3'd2;
    localparam logic [2:0] OP_EVICT_INDEX  = 3'd3;
    localparam logic [2:0] OP_INSTALL      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_FINISH
    } alru_state_t;

endpackage

FILE: sv/alru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alru_cell
// One table entry: valid bit and age, shifted on to the next cell on demand.
// ----------------------------------------------------------------------------
module alru_cell #(
    parameter int AGE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic                valid_in,
    input  logic [AGE_BITS-1:0] age_in,
    output logic                valid_out,
    output logic [AGE_BITS-1:0] age_out
);

    logic                valid_reg;
    logic [AGE_BITS-1:0] age_reg;
    logic                valid_next;
    logic [AGE_BITS-1:0] age_next;

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (shift_en)
        begin
            valid_next = valid_in;
            age_next   = age_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    assign valid_out = valid_reg;
    assign age_out   = age_reg;

endmodule

FILE: sv/alru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alru_ctrl
// Request sequencer: rotates the entry ring, updates the entry at its head
// and tracks the search result; holds the response register.
// ----------------------------------------------------------------------------
module alru_ctrl
    import alru_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int AGE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [3:0]          slot_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          slot,
    output logic                found,
    input  logic                head_valid,
    input  logic [AGE_BITS-1:0] head_age,
    output logic                tail_valid,
    output logic [AGE_BITS-1:0] tail_age,
    output logic                shift_en
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SW    = (IDX_W > 4) ? IDX_W : 4;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

    alru_state_t         state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [3:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                have_reg, have_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          slot_reg, slot_next;
    logic                found_reg, found_next;

    logic                idx_ok;
    logic                at_idx;
    logic                at_best;
    logic [SW-1:0]       best_ext;
    logic                res_found;
    logic [3:0]          res_slot;

    assign idx_ok   = {28'd0, idx_reg} < 32'(ENTRIES);
    assign at_idx   = SW'(cnt_reg) == SW'(idx_reg);
    assign at_best  = cnt_reg == best_reg;
    assign best_ext = SW'(best_reg);

    always_comb
    begin
        res_found = 1'b0;
        res_slot  = 4'd0;
        unique case (op_reg)
            OP_FIND_FREE, OP_EVICT_OLDEST:
            begin
                res_found = have_reg;
                res_slot  = have_reg ? best_ext[3:0] : 4'd0;
            end
            OP_EVICT_INDEX, OP_INSTALL:
            begin
                res_found = idx_ok;
                res_slot  = idx_ok ? idx_reg : 4'd0;
            end
            default:
            begin
                res_found = 1'b0;
                res_slot  = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        best_age_next  = best_age_reg;
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        in_ready       = 1'b0;
        shift_en       = 1'b0;
        tail_valid     = head_valid;
        tail_age       = head_age;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = opcode;
                    idx_next   = slot_index;
                    cnt_next   = '0;
                    have_next  = 1'b0;
                    best_next  = '0;
                    best_age_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                shift_en = 1'b1;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        if (head_valid && head_age != AGE_MAX)
                        begin
                            tail_age = head_age + AGE_ONE;
                        end
                    end
                    OP_FIND_FREE:
                    begin
                        if (!head_valid && !have_reg)
                        begin
                            have_next = 1'b1;
                            best_next = cnt_reg;
                        end
                    end
                    OP_EVICT_OLDEST:
                    begin
                        if (head_valid && (!have_reg || head_age > best_age_reg))
                        begin
                            have_next     = 1'b1;
                            best_next     = cnt_reg;
                            best_age_next = head_age;
                        end
                    end
                    OP_EVICT_INDEX:
                    begin
                        if (idx_ok && at_idx)
                        begin
                            tail_valid = 1'b0;
                            tail_age   = '0;
                        end
                    end
                    OP_INSTALL:
                    begin
                        if (idx_ok && at_idx)
                        begin
                            tail_valid = 1'b1;
                            tail_age   = '0;
                        end
                    end
                    default:
                    begin
                        tail_valid = head_valid;
                    end
                endcase
                if (cnt_reg == LAST)
                begin
                    cnt_next = '0;
                    if (op_reg == OP_EVICT_OLDEST && have_next)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CLEAR:
            begin
                shift_en = 1'b1;
                if (at_best)
                begin
                    tail_valid = 1'b0;
                    tail_age   = '0;
                end
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = res_slot;
                    found_next     = res_found;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        slot_reg     <= slot_next;
        found_reg    <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign found     = found_reg;

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_SCAN && cnt_reg == '0)
        else $error("accepted request did not start a scan");

    a_no_slot_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> slot_reg == 4'd0)
        else $error("slot non-zero on a miss");

    a_shift_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> state_reg == ST_SCAN || state_reg == ST_CLEAR)
        else $error("ring rotated outside a scan");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) < 32'(ENTRIES))
        else $error("scan position beyond table");

    a_clear_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> have_reg && op_reg == OP_EVICT_OLDEST)
        else $error("clear pass without a victim");

endmodule

FILE: sv/age_counter_lru_victim_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_counter_lru_victim_select_top
// LRU replacement with per-entry age counters over a ring of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_ready with opcode and slot_index.
//   Response channel: out_valid/out_ready with slot and found; one response
//   per request, in request order.
//   The entries sit in a ring of cells that rotates by one position a cycle
//   while a request runs; the entry at the ring head passes through the
//   update and search logic. A request makes one full rotation, and
//   evict_oldest that finds a victim makes two (search rotation, then
//   clearing rotation) before the response is loaded. The next request is
//   taken the cycle after the response is loaded, so a new request is not
//   taken while the previous one is still rotating the ring.
//   The response register frees the request side: a new request is taken
//   while a response still waits; if the receiver stalls, the following
//   response holds in the sequencer until the register is free.
//   Reset empties the table: every entry invalid with age zero.
// ----------------------------------------------------------------------------
module age_counter_lru_victim_select_top
    import alru_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int AGE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [3:0] slot_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] slot,
    output logic       found
);

    logic                cell_valid [ENTRIES];
    logic [AGE_BITS-1:0] cell_age   [ENTRIES];
    logic                tail_valid;
    logic [AGE_BITS-1:0] tail_age;
    logic                shift_en;

    alru_ctrl #(
        .ENTRIES  (ENTRIES),
        .AGE_BITS (AGE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .slot_index (slot_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot       (slot),
        .found      (found),
        .head_valid (cell_valid[0]),
        .head_age   (cell_age[0]),
        .tail_valid (tail_valid),
        .tail_age   (tail_age),
        .shift_en   (shift_en)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        if (i == ENTRIES - 1)
        begin : g_tail
            alru_cell #(
                .AGE_BITS (AGE_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .valid_in  (tail_valid),
                .age_in    (tail_age),
                .valid_out (cell_valid[i]),
                .age_out   (cell_age[i])
            );
        end
        else
        begin : g_body
            alru_cell #(
                .AGE_BITS (AGE_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .valid_in  (cell_valid[i+1]),
                .age_in    (cell_age[i+1]),
                .valid_out (cell_valid[i]),
                .age_out   (cell_age[i])
            );
        end
    end

endmodule

FILE: verif/age_counter_lru_victim_select_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_counter_lru_victim_select_top_tb
// Self-checking bench for the age counter LRU replacement block.
// A directed table covers the reset state, an empty table, ties, evicting a
// free slot, reinstalling a live slot and the unused codes. The table is then
// filled and checked full; back-to-back ticks age every entry. After that,
// random cache traffic follows: misses served from a free slot or by evicting
// the oldest entry, hits, ticks, evictions by index, flushes and noise.
// A local model of the table predicts every response. Random gaps appear on
// both sides, and long receiver hold-offs back the block up.
// ----------------------------------------------------------------------------
module age_counter_lru_victim_select_top_tb;

    import alru_pkg::*;

    localparam int N_ENTRIES       = 16;
    localparam int AGE_W           = 16;
    localparam int NO_SLOT         = -1;
    localparam int RANDOM_ITEMS    = 1850;
    localparam int AGE_TICKS       = 24;
    localparam int MAX_GAP         = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int CYCLE_LIMIT     = 5_000_000;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [3:0] slot;
        logic       found;
    } resp_t;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] idx;
        logic       typed;
        logic [3:0] slot;
        logic       found;
    } dir_row_t;

    localparam int N_DIR = 19;

    localparam dir_row_t [0:N_DIR-1] DIR_ROWS = {
        {OP_TICK,         4'd0,  TYPED,     4'd0,  1'b0},
        {OP_FIND_FREE,    4'd15, TYPED,     4'd0,  1'b1},
        {OP_EVICT_OLDEST, 4'd0,  TYPED,     4'd0,  1'b0},
        {OP_EVICT_INDEX,  4'd15, TYPED,     4'd15, 1'b1},
        {OP_INSTALL,      4'd0,  TYPED,     4'd0,  1'b1},
        {OP_INSTALL,      4'd15, TYPED,     4'd15, 1'b1},
        {OP_TICK,         4'd9,  TYPED,     4'd0,  1'b0},
        {OP_INSTALL,      4'd7,  TYPED,     4'd7,  1'b1},
        {OP_FIND_FREE,    4'd0,  PREDICTED, 4'd0,  1'b0},
        {OP_EVICT_OLDEST, 4'd5,  PREDICTED, 4'd0,  1'b0},
        {OP_INSTALL,      4'd15, TYPED,     4'd15, 1'b1},
        {OP_TICK,         4'd15, TYPED,     4'd0,  1'b0},
        {OP_EVICT_OLDEST, 4'd0,  PREDICTED, 4'd0,  1'b0},
        {OP_EVICT_INDEX,  4'd15, TYPED,     4'd15, 1'b1},
        {OP_EVICT_INDEX,  4'd15, TYPED,     4'd15, 1'b1},
        {OP_RSVD_5,       4'd3,  TYPED,     4'd0,  1'b0},
        {OP_RSVD_6,       4'd15, TYPED,     4'd0,  1'b0},
        {OP_RSVD_7,       4'd0,  TYPED,     4'd0,  1'b0},
        {OP_EVICT_OLDEST, 4'd10, PREDICTED, 4'd0,  1'b0}
    };

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [2:0] opcode     = OP_TICK;
    logic [3:0] slot_index = 4'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [3:0] slot;
    logic       found;

    logic       drv_typed = 1'b0;
    resp_t      drv_want  = '0;

    logic             tbl_valid [N_ENTRIES];
    logic [AGE_W-1:0] tbl_age   [N_ENTRIES];
    resp_t            want_q    [$];

    logic no_idle          = 1'b0;
    logic hold_off_pending = 1'b0;

    int req_taken   = 0;
    int resp_seen   = 0;
    int slots_seen  = 0;
    int hold_offs   = 0;
    int fails       = 0;
    int mismatches  = 0;
    int cycles      = 0;
    int op_seen [8] = '{default: 0};

    age_counter_lru_victim_select_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .slot_index (slot_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot       (slot),
        .found      (found)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, want_q.size());
            $display("age_counter_lru_victim_select_top_tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 12);
        return $urandom_range(13, MAX_GAP);
    endfunction

    function automatic int lowest_free();
        int pick;
        pick = NO_SLOT;
        for (int i = N_ENTRIES - 1; i >= 0; i--)
            if (!tbl_valid[i])
                pick = i;
        return pick;
    endfunction

    function automatic int oldest_valid();
        int pick;
        pick = NO_SLOT;
        for (int i = 0; i < N_ENTRIES; i++)
            if (tbl_valid[i] && (pick == NO_SLOT || tbl_age[i] > tbl_age[pick]))
                pick = i;
        return pick;
    endfunction

    function automatic resp_t lru_apply(input logic [2:0] op, input logic [3:0] idx);
        resp_t r;
        int    pick;
        r = '0;
        case (op)
            OP_TICK:
            begin
                for (int i = 0; i < N_ENTRIES; i++)
                    if (tbl_valid[i] && tbl_age[i] != AGE_MAX)
                        tbl_age[i] = tbl_age[i] + 1'b1;
            end
            OP_FIND_FREE:
            begin
                pick = lowest_free();
                if (pick != NO_SLOT)
                begin
                    r.slot  = pick[3:0];
                    r.found = 1'b1;
                end
            end
            OP_EVICT_OLDEST:
            begin
                pick = oldest_valid();
                if (pick != NO_SLOT)
                begin
                    tbl_valid[pick] = 1'b0;
                    tbl_age[pick]   = '0;
                    r.slot          = pick[3:0];
                    r.found         = 1'b1;
                end
            end
            OP_EVICT_INDEX:
            begin
                if (int'(idx) < N_ENTRIES)
                begin
                    tbl_valid[idx] = 1'b0;
                    tbl_age[idx]   = '0;
                    r.slot         = idx;
                    r.found        = 1'b1;
                end
            end
            OP_INSTALL:
            begin
                if (int'(idx) < N_ENTRIES)
                begin
                    tbl_valid[idx] = 1'b1;
                    tbl_age[idx]   = '0;
                    r.slot         = idx;
                    r.found        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // predict on acceptance, check each response against the oldest prediction
    always @(posedge clk)
    begin : monitor
        resp_t want;
        resp_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = lru_apply(opcode, slot_index);
                if (drv_typed)
                    want = drv_want;
                want_q.push_back(want);
                op_seen[opcode]++;
                req_taken++;
            end
            if (out_valid && out_ready)
            begin
                got.slot  = slot;
                got.found = found;
                resp_seen++;
                if (found === 1'b1)
                    slots_seen++;
                if (want_q.size() == 0)
                begin
                    fails++;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected response %0d: slot %0d found %0b",
                                 resp_seen, got.slot, got.found);
                    mismatches++;
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got.slot !== want.slot || got.found !== want.found)
                    begin
                        fails++;
                        if (mismatches < MAX_REPORTS)
                            $display("response %0d: got %0d/%0b, expected %0d/%0b",
                                     resp_seen, got.slot, got.found,
                                     want.slot, want.found);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_offs++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // hold valid and payload until the request is taken
    task automatic send_request(input logic [2:0] op, input logic [3:0] idx,
                                input logic typed, input resp_t want);
        int gap;
        int taken;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        slot_index <= idx;
        drv_typed  <= typed;
        drv_want   <= want;
        taken = req_taken;
        do
            @(negedge clk);
        while (req_taken == taken);
    endtask

    initial
    begin : stimulus
        dir_row_t   row;
        resp_t      want;
        logic [2:0] op;
        logic [3:0] idx;
        int         victim;
        int         items;
        int         hold_at;
        int         r;
        int         n;

        for (int i = 0; i < N_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_age[i]   = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < N_DIR; k++)
        begin
            row        = DIR_ROWS[k];
            want.slot  = row.slot;
            want.found = row.found;
            send_request(row.op, row.idx, row.typed, want);
        end

        // fill the table, then age every entry
        for (int k = 0; k < N_ENTRIES; k++)
            send_request(OP_INSTALL, k[3:0], PREDICTED, '0);
        send_request(OP_FIND_FREE, 4'd6, TYPED, '0);
        send_request(OP_EVICT_INDEX, 4'd9, TYPED, {4'd9, 1'b1});
        send_request(OP_INSTALL, 4'd9, TYPED, {4'd9, 1'b1});
        no_idle = 1'b1;
        for (int k = 0; k < AGE_TICKS; k++)
            send_request(OP_TICK, 4'd0, PREDICTED, '0);
        no_idle = 1'b0;
        send_request(OP_EVICT_OLDEST, 4'd0, PREDICTED, '0);
        send_request(OP_INSTALL, 4'd0, PREDICTED, '0);
        send_request(OP_TICK, 4'd0, PREDICTED, '0);
        send_request(OP_EVICT_OLDEST, 4'd0, PREDICTED, '0);

        items   = 0;
        hold_at = 500;
        while (items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 149) == 0)
                no_idle = ~no_idle;
            if (items >= hold_at)
            begin
                hold_off_pending = 1'b1;
                hold_at          = hold_at + 800;
            end
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                victim = lowest_free();
                if (victim != NO_SLOT)
                    send_request(OP_FIND_FREE, 4'($urandom_range(0, 15)), PREDICTED, '0);
                else
                begin
                    victim = oldest_valid();
                    send_request(OP_EVICT_OLDEST, 4'($urandom_range(0, 15)), PREDICTED, '0);
                end
                send_request(OP_INSTALL, victim[3:0], PREDICTED, '0);
                items += 2;
            end
            else if (r < 55)
            begin
                victim = $urandom_range(0, N_ENTRIES - 1);
                for (int k = 0; k < N_ENTRIES && !tbl_valid[victim]; k++)
                    victim = (victim + 1) % N_ENTRIES;
                send_request(OP_INSTALL, victim[3:0], PREDICTED, '0);
                items++;
            end
            else if (r < 75)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_request(OP_TICK, 4'($urandom_range(0, 15)), PREDICTED, '0);
                items += n;
            end
            else if (r < 85)
            begin
                send_request(OP_EVICT_INDEX, 4'($urandom_range(0, 15)), PREDICTED, '0);
                items++;
            end
            else if (r < 92)
            begin
                send_request(OP_EVICT_OLDEST, 4'($urandom_range(0, 15)), PREDICTED, '0);
                items++;
            end
            else if (r < 97)
            begin
                op  = 3'($urandom_range(0, 7));
                idx = 4'($urandom_range(0, 15));
                send_request(op, idx, PREDICTED, '0);
                items++;
            end
            else
            begin
                // flush: evict until empty, then once more on the empty table
                while (oldest_valid() != NO_SLOT)
                begin
                    send_request(OP_EVICT_OLDEST, 4'($urandom_range(0, 15)), PREDICTED, '0);
                    items++;
                end
                send_request(OP_EVICT_OLDEST, 4'($urandom_range(0, 15)), PREDICTED, '0);
                items++;
            end
        end
        in_valid <= 1'b0;

        while (want_q.size() != 0)
            @(negedge clk);
        repeat (2 * N_ENTRIES + 4) @(negedge clk);

        $display("%0d requests (tick %0d find %0d oldest %0d index %0d install %0d other %0d)",
                 req_taken, op_seen[OP_TICK], op_seen[OP_FIND_FREE],
                 op_seen[OP_EVICT_OLDEST], op_seen[OP_EVICT_INDEX], op_seen[OP_INSTALL],
                 op_seen[OP_RSVD_5] + op_seen[OP_RSVD_6] + op_seen[OP_RSVD_7]);
        $display("%0d responses, %0d with a slot, %0d hold-offs, %0d mismatches, %0d cycles",
                 resp_seen, slots_seen, hold_offs, mismatches, cycles);
        if (fails == 0)
            $display("age_counter_lru_victim_select_top_tb OK");
        else
            $display("age_counter_lru_victim_select_top_tb NOT OK");
        $finish;
    end

endmodule
